// ===== src/ipv4hc_pkg.sv =====
// Types and constants shared by the IPv4 header receive check.
`timescale 1ns / 1ps

package ipv4hc_pkg;

  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [5:0]  HDR_MIN    = 6'd20;
  localparam logic [3:0]  IP_VERSION = 4'd4;
  localparam logic [15:0] FRAG_MF    = 16'h2000;
  localparam logic [15:0] FRAG_OFS   = 16'h1fff;
  localparam logic [31:0] BCAST_ALL  = 32'hffff_ffff;

  typedef enum logic [3:0] {
    ST_OK      = 4'd0,
    ST_SHORT   = 4'd1,
    ST_VERSION = 4'd2,
    ST_HDRLEN  = 4'd3,
    ST_TOTLEN  = 4'd4,
    ST_CKSUM   = 4'd5,
    ST_FRAG    = 4'd6,
    ST_NOIFACE = 4'd7,
    ST_NOTMINE = 4'd8,
    ST_NOPROTO = 4'd9
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOCAL_UNICAST = 4'd0,
    REG_LOCAL_NETMASK = 4'd1,
    REG_IFACE_ENABLE  = 4'd2,
    REG_PROTO_MASK    = 4'd3,
    REG_PROTO_TYPE_0  = 4'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [15:0] frame_len;
    logic        last_byte;
  } in_t;

  typedef struct packed {
    status_e     status;
    logic [1:0]  handler_slot;
    logic [7:0]  protocol;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [5:0]  header_len;
    logic [15:0] payload_len;
  } out_t;

  typedef struct packed {
    logic                  we;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] wdata;
  } cfg_wr_t;

endpackage

// ===== src/ipv4hc_parse.sv =====
// Per-byte header capture, checksum accumulation and verdict logic.
`timescale 1ns / 1ps

module ipv4hc_parse import ipv4hc_pkg::*; #(
  parameter int unsigned PROTO_SLOTS = 4
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_wr_t cfg_i,
  input  logic    fire_i,
  input  in_t     in_i,
  output logic    res_valid_o,
  output out_t    res_o
);

  localparam logic [5:0] POS_TL_HI = 6'd2;
  localparam logic [5:0] POS_TL_LO = 6'd3;
  localparam logic [5:0] POS_FR_HI = 6'd6;
  localparam logic [5:0] POS_FR_LO = 6'd7;
  localparam logic [5:0] POS_PROTO = 6'd9;

  logic [31:0] unicast_q, netmask_q;
  logic        iface_en_q;
  logic [3:0]  proto_mask_q;
  logic [7:0]  proto_type_q [PROTO_SLOTS];

  logic [5:0]  byte_cnt_q, byte_cnt_d;
  logic        sent_q, sent_d;
  logic [15:0] flen_q, flen_d;
  logic [7:0]  ver_q, ver_d;
  logic [15:0] tlen_q, tlen_d;
  logic [15:0] frag_q, frag_d;
  logic [7:0]  proto_q, proto_d;
  logic [31:0] src_q, src_d;
  logic [31:0] dst_q, dst_d;
  logic [15:0] acc_q, acc_d;
  logic [7:0]  hb_q, hb_d;

  logic        first;
  logic [7:0]  d;
  logic [16:0] sum;
  logic [5:0]  hlen;
  logic [31:0] bcast;
  logic        decided;
  status_e     status;
  logic        hit;
  logic [1:0]  slot;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unicast_q    <= '0;
      netmask_q    <= '0;
      iface_en_q   <= 1'b0;
      proto_mask_q <= '0;
      for (int k = 0; k < PROTO_SLOTS; k++) proto_type_q[k] <= '0;
    end else if (cfg_i.we) begin
      case (cfg_i.idx)
        REG_LOCAL_UNICAST: unicast_q    <= cfg_i.wdata;
        REG_LOCAL_NETMASK: netmask_q    <= cfg_i.wdata;
        REG_IFACE_ENABLE:  iface_en_q   <= cfg_i.wdata[0];
        REG_PROTO_MASK:    proto_mask_q <= cfg_i.wdata[3:0];
        default: begin
          for (int k = 0; k < PROTO_SLOTS; k++) begin
            if (cfg_i.idx == CFG_IDX_W'(REG_PROTO_TYPE_0) + CFG_IDX_W'(k))
              proto_type_q[k] <= cfg_i.wdata[7:0];
          end
        end
      endcase
    end
  end

  // field capture and checksum
  always_comb begin
    d     = in_i.data_byte;
    first = (byte_cnt_q == '0);

    flen_d  = first ? in_i.frame_len : flen_q;
    ver_d   = first ? d : ver_q;
    tlen_d  = first ? '0 : tlen_q;
    frag_d  = first ? '0 : frag_q;
    proto_d = first ? '0 : proto_q;
    src_d   = first ? '0 : src_q;
    dst_d   = first ? '0 : dst_q;
    acc_d   = first ? '0 : acc_q;
    hb_d    = first ? '0 : hb_q;

    case (byte_cnt_q)
      POS_TL_HI: tlen_d[15:8] = d;
      POS_TL_LO: tlen_d[7:0]  = d;
      POS_FR_HI: frag_d[15:8] = d;
      POS_FR_LO: frag_d[7:0]  = d;
      POS_PROTO: proto_d      = d;
      default: begin
        if (byte_cnt_q inside {[6'd12:6'd15]}) src_d = {src_q[23:0], d};
        else if (byte_cnt_q inside {[6'd16:6'd19]}) dst_d = {dst_q[23:0], d};
      end
    endcase

    sum = '0;
    if (!byte_cnt_q[0]) begin
      hb_d = d;
    end else begin
      sum   = {1'b0, acc_q} + {1'b0, hb_q, d};
      acc_d = sum[15:0] + {15'd0, sum[16]};
    end
  end

  // verdict
  always_comb begin
    hlen    = {ver_d[3:0], 2'b00};
    bcast   = (unicast_q & netmask_q) | ~netmask_q;
    decided = 1'b0;
    status  = ST_OK;
    hit     = 1'b0;
    slot    = '0;

    for (int k = PROTO_SLOTS - 1; k >= 0; k--) begin
      if (proto_mask_q[k] && proto_type_q[k] == proto_d) begin
        hit  = 1'b1;
        slot = 2'(k);
      end
    end

    if (first) begin
      decided = 1'b1;
      if (flen_d < 16'(HDR_MIN)) status = ST_SHORT;
      else if (ver_d[7:4] != IP_VERSION) status = ST_VERSION;
      else if (hlen < HDR_MIN || 16'(hlen) > flen_d) status = ST_HDRLEN;
      else decided = 1'b0;
    end
    if (!decided && byte_cnt_q == POS_TL_LO) begin
      if (tlen_d > flen_d || tlen_d < 16'(hlen)) begin
        status  = ST_TOTLEN;
        decided = 1'b1;
      end
    end
    if (!decided && (7'(byte_cnt_q) + 7'd1) == 7'(hlen)) begin
      decided = 1'b1;
      if (acc_d != 16'hffff) status = ST_CKSUM;
      else if ((frag_d & (FRAG_MF | FRAG_OFS)) != '0) status = ST_FRAG;
      else if (!iface_en_q) status = ST_NOIFACE;
      else if (dst_d != unicast_q && dst_d != BCAST_ALL && dst_d != bcast)
        status = ST_NOTMINE;
      else if (!hit) status = ST_NOPROTO;
      else status = ST_OK;
    end
    if (!decided && in_i.last_byte) begin
      status  = ST_SHORT;
      decided = 1'b1;
    end
  end

  always_comb begin
    res_valid_o        = fire_i && !sent_q && decided;
    res_o.status       = status;
    res_o.handler_slot = (status == ST_OK) ? slot : '0;
    res_o.protocol     = proto_d;
    res_o.src_addr     = src_d;
    res_o.dst_addr     = dst_d;
    res_o.header_len   = hlen;
    res_o.payload_len  = (status == ST_OK) ? (tlen_d - 16'(hlen)) : '0;

    if (sent_q) begin
      byte_cnt_d = in_i.last_byte ? '0 : byte_cnt_q;
      sent_d     = !in_i.last_byte;
    end else begin
      byte_cnt_d = in_i.last_byte ? '0 : byte_cnt_q + 6'd1;
      sent_d     = !in_i.last_byte && decided;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_cnt_q <= '0;
      sent_q     <= 1'b0;
      flen_q     <= '0;
      ver_q      <= '0;
      tlen_q     <= '0;
      frag_q     <= '0;
      proto_q    <= '0;
      src_q      <= '0;
      dst_q      <= '0;
      acc_q      <= '0;
      hb_q       <= '0;
    end else if (fire_i) begin
      byte_cnt_q <= byte_cnt_d;
      sent_q     <= sent_d;
      if (!sent_q) begin
        flen_q  <= flen_d;
        ver_q   <= ver_d;
        tlen_q  <= tlen_d;
        frag_q  <= frag_d;
        proto_q <= proto_d;
        src_q   <= src_d;
        dst_q   <= dst_d;
        acc_q   <= acc_d;
        hb_q    <= hb_d;
      end
    end
  end

endmodule

// ===== src/ipv4_header_receive_check.sv =====
// Top level of the IPv4 header receive check with its two-entry result buffer.
`timescale 1ns / 1ps

// Takes one frame byte per transaction and gives one verdict transaction per
// frame. Every byte is handled in the cycle it is accepted, so a byte can be
// taken in every clock while in_ready_o is high. The verdict is registered,
// in the output or skid register, from the byte that settles it: the first
// byte for short, version and header length errors, byte 3 for total length,
// the last header byte for the remaining checks, or the last frame byte if
// the frame ends early. Bytes after a verdict are dropped up to the end of
// the frame. Results go through an output register backed by a skid register,
// and in_ready_o falls only while both hold a result. Configuration writes
// take effect on the next clock and are meant for idle periods between frames.
module ipv4_header_receive_check import ipv4hc_pkg::*; #(
  parameter int unsigned PROTO_SLOTS = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_t                   in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_t                  out_data_o
);

  cfg_wr_t cfg;
  logic    fire;
  logic    res_valid;
  out_t    res;

  logic    out_valid_q, skid_valid_q;
  out_t    out_q, skid_q;

  assign cfg.we    = cfg_we_i;
  assign cfg.idx   = cfg_idx_i;
  assign cfg.wdata = cfg_wdata_i;

  assign in_ready_o = !skid_valid_q;
  assign fire       = in_valid_i && in_ready_o;

  ipv4hc_parse #(
    .PROTO_SLOTS (PROTO_SLOTS)
  ) u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .fire_i      (fire),
    .in_i        (in_data_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || out_ready_i) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_ready_i) begin
      out_q <= skid_valid_q ? skid_q : res;
    end else if (res_valid) begin
      skid_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid register full while output register empty");

  a_skid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q && !out_ready_i |=> skid_valid_q && $stable(skid_q))
    else $error("skid register changed while output stalled");

  a_err_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.status != ST_OK |->
      out_q.handler_slot == '0 && out_q.payload_len == '0)
    else $error("slot or payload length set on a rejected frame");

endmodule
